// ===== src/urlpd_pkg.sv =====
// ---------------------------------------------------------------------------
// urlpd_pkg
// Types, character codes and hex helpers shared by the percent decoder.
// ---------------------------------------------------------------------------
package urlpd_pkg;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_DEL     = 8'd127;
  localparam logic [7:0] CH_FIRST_PRINT = 8'd32;

  // Slots in one decoded group and queue depth.
  localparam int GROUP_SLOTS = 3;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_req_t;

  // Up to three decoded bytes produced by one input byte.
  typedef struct packed {
    logic [GROUP_SLOTS-1:0][7:0] data;
    logic [1:0]                  count;
    logic                        last;
  } group_t;

  function automatic logic hex_ok(input logic [7:0] c);
    hex_ok = (c >= 8'h30 && c <= 8'h39) ||
             (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h41 + 8'd10;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h61 + 8'd10;
    end else begin
      v = 8'h00;
    end
    hex_nib = v[3:0];
  endfunction

endpackage

// ===== src/urlpd_front.sv =====
// ---------------------------------------------------------------------------
// urlpd_front
// Escape tracker: takes raw bytes and builds a group of decoded bytes.
// ---------------------------------------------------------------------------
module urlpd_front import urlpd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    take,
  input  in_req_t req,
  output logic    push,
  output group_t  grp
);

  phase_t     phase, phase_next;
  logic [7:0] held_digit, held_digit_next;

  logic [7:0] b;
  logic [7:0] decoded;

  assign b = req.in_byte;

  always_comb begin
    decoded = {hex_nib(held_digit), hex_nib(b)};
    if (decoded < CH_FIRST_PRINT || decoded == CH_DEL) begin
      decoded = CH_UNDER;
    end
  end

  // Next escape state.
  always_comb begin
    phase_next      = phase;
    held_digit_next = held_digit;
    case (phase)
      PH_PCT: begin
        if (hex_ok(b)) begin
          held_digit_next = b;
          phase_next      = PH_DIGIT;
        end else begin
          phase_next = (b == CH_PERCENT) ? PH_PCT : PH_IDLE;
        end
      end
      PH_DIGIT: begin
        held_digit_next = 8'h00;
        if (hex_ok(b)) begin
          phase_next = PH_IDLE;
        end else begin
          phase_next = (b == CH_PERCENT) ? PH_PCT : PH_IDLE;
        end
      end
      default: begin
        phase_next = (b == CH_PERCENT) ? PH_PCT : PH_IDLE;
      end
    endcase
    if (req.in_last) begin
      phase_next      = PH_IDLE;
      held_digit_next = 8'h00;
    end
  end

  // Output group: fill slots in order.
  always_comb begin
    logic [1:0] n;
    logic       plain;
    phase_t     mid;
    n     = 2'd0;
    plain = 1'b0;
    mid   = PH_IDLE;
    grp   = '0;
    case (phase)
      PH_PCT: begin
        if (hex_ok(b)) begin
          mid = PH_DIGIT;
        end else begin
          grp.data[n] = CH_PERCENT;
          n           = n + 2'd1;
          plain       = 1'b1;
        end
      end
      PH_DIGIT: begin
        if (hex_ok(b)) begin
          grp.data[n] = decoded;
          n           = n + 2'd1;
        end else begin
          grp.data[n] = CH_PERCENT;
          n           = n + 2'd1;
          grp.data[n] = held_digit;
          n           = n + 2'd1;
          plain       = 1'b1;
        end
      end
      default: begin
        plain = 1'b1;
      end
    endcase
    if (plain) begin
      if (b == CH_PLUS) begin
        grp.data[n] = CH_SPACE;
        n           = n + 2'd1;
      end else if (b == CH_PERCENT) begin
        mid = PH_PCT;
      end else begin
        grp.data[n] = b;
        n           = n + 2'd1;
      end
    end
    // Flush an escape left open at end of string.
    if (req.in_last) begin
      if (mid == PH_PCT) begin
        grp.data[n] = CH_PERCENT;
        n           = n + 2'd1;
      end else if (mid == PH_DIGIT) begin
        grp.data[n] = CH_PERCENT;
        n           = n + 2'd1;
        grp.data[n] = b;
        n           = n + 2'd1;
      end
    end
    grp.count = n;
    grp.last  = req.in_last;
    push      = take && (n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      held_digit <= 8'h00;
    end else if (take) begin
      phase      <= phase_next;
      held_digit <= held_digit_next;
    end
  end

endmodule

// ===== src/urlpd_queue.sv =====
// ---------------------------------------------------------------------------
// urlpd_queue
// Small FIFO of decoded groups between the front and back parts.
// ---------------------------------------------------------------------------
module urlpd_queue import urlpd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  group_t push_grp,
  input  logic   pop,
  output group_t head,
  output logic   empty,
  output logic   full
);

  group_t            slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   fill;

  assign empty = (fill == '0);
  assign full  = (fill == (QPTR_W+1)'(QDEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== src/urlpd_back.sv =====
// ---------------------------------------------------------------------------
// urlpd_back
// Serializer: sends the bytes of the head group one per cycle, unless stalled.
// ---------------------------------------------------------------------------
module urlpd_back import urlpd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  group_t   head,
  input  logic     empty,
  output logic     pop,
  output logic     dn_valid,
  input  logic     dn_stall,
  output out_req_t dn_req
);

  logic [1:0] idx;
  logic       load;
  logic       at_end;

  assign load   = !empty && (!dn_valid || !dn_stall);
  assign at_end = (idx == head.count - 2'd1);
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= 2'd0;
      dn_valid <= 1'b0;
    end else begin
      if (load) begin
        idx      <= at_end ? 2'd0 : idx + 2'd1;
        dn_valid <= 1'b1;
      end else if (!dn_stall) begin
        dn_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dn_req.out_byte <= head.data[idx];
      dn_req.out_last <= head.last && at_end;
    end
  end

endmodule

// ===== src/url_percent_decoder.sv =====
// ---------------------------------------------------------------------------
// url_percent_decoder
// Percent decoder for URL query strings, one raw byte per request.
// ---------------------------------------------------------------------------
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------
//   up      | up_valid / up_stall | up_req: in_byte, in_last
//   dn      | dn_valid / dn_stall | dn_req: out_byte, out_last
//
// Cycles: one input request per cycle unless stalled; each makes 0 to 3
//   output bytes, sent one per cycle, so output bandwidth of one byte per
//   cycle sets the sustained rate. Bytes pass queue then output register.
// Reset: rst, synchronous, clears escape state, queue and output valid.
// Stalls: up_stall rises when the four-group queue is full; dn_stall
//   holds the output register and the queue absorbs the input side.
//
module url_percent_decoder import urlpd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     up_valid,
  output logic     up_stall,
  input  in_req_t  up_req,
  output logic     dn_valid,
  input  logic     dn_stall,
  output out_req_t dn_req
);

  logic   take;
  logic   push;
  group_t grp;
  logic   pop;
  group_t head;
  logic   empty;
  logic   full;

  // Hold the input side only while the queue has no free slot.
  assign up_stall = full;
  assign take     = up_valid && !up_stall;

  // Front: track escapes, turn each request into a group of bytes.
  urlpd_front u_front (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .req  (up_req),
    .push (push),
    .grp  (grp)
  );

  // Queue: decouple front from back.
  urlpd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_grp (grp),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  // Back: advance through the head group, one byte per cycle unless stalled.
  urlpd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .dn_valid (dn_valid),
    .dn_stall (dn_stall),
    .dn_req   (dn_req)
  );

endmodule

// ===== dv/urlpd_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// urlpd_checker
// Watches both channels of the percent decoder, predicts the decoded bytes
// of every accepted request and compares them in order with the output.
// ---------------------------------------------------------------------------
module urlpd_checker import urlpd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     up_valid,
  input  logic     up_stall,
  input  in_req_t  up_req,
  input  logic     dn_valid,
  input  logic     dn_stall,
  input  out_req_t dn_req,
  output int       fail_count,
  output int       outstanding
);

  phase_t     esc_phase;
  logic [7:0] held_digit;
  out_req_t   decoded_q[$];   // bytes still owed by the block, oldest first
  out_req_t   step_bytes[$];  // bytes made by the current request
  int         report_cnt;

  // Bit 4 set means not a hex digit.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, 4'(c - 8'h30)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b0, 4'(c - 8'h41 + 8'd10)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b0, 4'(c - 8'h61 + 8'd10)};
    return 5'h10;
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    out_req_t r;
    r.out_byte = b;
    r.out_last = 1'b0;
    step_bytes.insert(step_bytes.size(), r);
  endfunction

  function automatic void plain_byte(input logic [7:0] b);
    if (b == CH_PLUS) begin
      put_byte(CH_SPACE);
    end else if (b == CH_PERCENT) begin
      esc_phase = PH_PCT;
    end else begin
      put_byte(b);
    end
  endfunction

  function automatic void decode_request(input in_req_t r);
    logic [4:0] hv;
    logic [4:0] hh;
    logic [7:0] val;
    step_bytes.delete();
    hv = hex_decode(r.in_byte);
    case (esc_phase)
      PH_PCT: begin
        if (!hv[4]) begin
          held_digit = r.in_byte;
          esc_phase  = PH_DIGIT;
        end else begin
          put_byte(CH_PERCENT);
          esc_phase = PH_IDLE;
          plain_byte(r.in_byte);
        end
      end
      PH_DIGIT: begin
        if (!hv[4]) begin
          hh  = hex_decode(held_digit);
          val = {hh[3:0], hv[3:0]};
          // control codes and DEL are masked
          if (val < CH_FIRST_PRINT || val == CH_DEL) val = CH_UNDER;
          put_byte(val);
        end else begin
          put_byte(CH_PERCENT);
          put_byte(held_digit);
          esc_phase = PH_IDLE;
          plain_byte(r.in_byte);
        end
        if (esc_phase == PH_DIGIT) esc_phase = PH_IDLE;
        held_digit = 8'h00;
      end
      default: begin
        esc_phase = PH_IDLE;
        plain_byte(r.in_byte);
      end
    endcase
    if (r.in_last) begin
      // flush an escape left open at the end of the string
      if (esc_phase == PH_PCT) begin
        put_byte(CH_PERCENT);
      end else if (esc_phase == PH_DIGIT) begin
        put_byte(CH_PERCENT);
        put_byte(held_digit);
      end
      esc_phase  = PH_IDLE;
      held_digit = 8'h00;
      if (step_bytes.size() > 0) step_bytes[step_bytes.size() - 1].out_last = 1'b1;
    end
    foreach (step_bytes[i]) decoded_q.insert(decoded_q.size(), step_bytes[i]);
  endfunction

  always @(posedge clk) begin
    out_req_t want;
    if (rst) begin
      decoded_q.delete();
      esc_phase  = PH_IDLE;
      held_digit = 8'h00;
      fail_count = 0;
      report_cnt = 0;
    end else begin
      if (up_valid && !up_stall) decode_request(up_req);
      if (dn_valid && !dn_stall) begin
        if (decoded_q.size() == 0) begin
          fail_count++;
          if (report_cnt < 10) begin
            report_cnt++;
            $display("unexpected output: expected none, got byte %02h last %0b",
                     dn_req.out_byte, dn_req.out_last);
          end
        end else begin
          want = decoded_q.pop_front();
          if (want.out_byte !== dn_req.out_byte || want.out_last !== dn_req.out_last) begin
            fail_count++;
            if (report_cnt < 10) begin
              report_cnt++;
              $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                       want.out_byte, want.out_last, dn_req.out_byte, dn_req.out_last);
            end
          end
        end
      end
    end
    outstanding = decoded_q.size();
  end

endmodule

// ===== dv/tb_url_percent_decoder.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_url_percent_decoder
// Drives encoded query strings into the percent decoder under random
// backpressure and idling; the checker beside the block judges the output.
// ---------------------------------------------------------------------------
module tb_url_percent_decoder;
  import urlpd_pkg::*;

  logic     clk;
  logic     rst;
  logic     up_valid;
  logic     up_stall;
  in_req_t  up_req;
  logic     dn_valid;
  logic     dn_stall;
  out_req_t dn_req;

  int fail_count;
  int outstanding;

  // Shared knobs between the sender and the receiver processes.
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit long_hold  = 1'b0;
  bit gap_ok     = 1'b1;
  int reqs_sent  = 0;

  logic [7:0] msg[$];  // string being sent

  url_percent_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .up_valid (up_valid),
    .up_stall (up_stall),
    .up_req   (up_req),
    .dn_valid (dn_valid),
    .dn_stall (dn_stall),
    .dn_req   (dn_req)
  );

  urlpd_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (up_valid),
    .up_stall    (up_stall),
    .up_req      (up_req),
    .dn_valid    (dn_valid),
    .dn_stall    (dn_stall),
    .dn_req      (dn_req),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

  // Random hex digit, either case for the letters.
  function automatic logic [7:0] rand_hex();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'(8'h30 + v);
    if ($urandom_range(0, 1) == 1) return 8'(8'h41 + v - 10);
    return 8'(8'h61 + v - 10);
  endfunction

  // Append one byte to the string being built.
  function automatic void add_byte(input logic [7:0] b);
    msg.insert(msg.size(), b);
  endfunction

  // Offer one request at the falling edge and hold it until accepted.
  task automatic send_req(input logic [7:0] b, input logic l);
    up_req.in_byte <= b;
    up_req.in_last <= l;
    up_valid       <= 1'b1;
    do @(posedge clk); while (up_stall);
    reqs_sent++;
    @(negedge clk);
  endtask

  // Drop valid for a random burst, unless the receiver is being held off.
  task automatic sender_gap();
    if (tx_idle_on && gap_ok && !long_hold && $urandom_range(0, 3) == 0) begin
      up_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
  endtask

  // Send msg as one string, last flag on its final byte.
  task automatic send_msg();
    gap_ok = 1'($urandom_range(0, 1));
    foreach (msg[i]) begin
      send_req(msg[i], i == msg.size() - 1);
      sender_gap();
    end
    msg.delete();
  endtask

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    dn_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (long_hold) begin
        // hold the output long enough that the group queue fills up
        dn_stall <= 1'b1;
        repeat (80) @(negedge clk);
        long_hold = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        dn_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end else begin
        dn_stall <= 1'b0;
        @(negedge clk);
      end
    end
  end

  // Sender: directed strings, then random ones, then the verdict.
  initial begin
    int k;
    int n_tok;
    bit held_once;
    bit paused_once;
    held_once   = 1'b0;
    paused_once = 1'b0;
    rst      = 1'b1;
    up_valid = 1'b0;
    up_req   = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Extremes and '+' with the string ending on the space.
    msg = '{8'h00, 8'hFF, CH_PLUS};
    send_msg();
    // Plain escapes: letter, masked control code, masked DEL, top value.
    msg = '{CH_PERCENT, "4", "1", CH_PERCENT, "0", "a",
            CH_PERCENT, "7", "F", CH_PERCENT, "F", "f"};
    send_msg();
    // Bad first digit, twice in a row, with a '%' as the bad digit.
    msg = '{CH_PERCENT, CH_PERCENT, "Z"};
    send_msg();
    // Bad second digit that opens a new escape.
    msg = '{CH_PERCENT, "3", CH_PERCENT, "4", "1"};
    send_msg();
    // Escapes left open at the end of the string.
    msg = '{CH_PERCENT};
    send_msg();
    msg = '{CH_PERCENT, "9"};
    send_msg();

    while (reqs_sent < 210) begin
      n_tok = $urandom_range(1, 6);
      repeat (n_tok) begin
        k = $urandom_range(0, 99);
        if (k < 40) begin
          add_byte(CH_PERCENT);
          add_byte(rand_hex());
          add_byte(rand_hex());
        end else if (k < 52) begin
          add_byte(CH_PLUS);
        end else if (k < 72) begin
          add_byte(8'($urandom_range(8'h21, 8'h7E)));
        end else if (k < 84) begin
          add_byte(8'($urandom_range(0, 255)));
        end else if (k < 92) begin
          add_byte(CH_PERCENT);
          add_byte(8'($urandom_range(0, 255)));
        end else begin
          add_byte(CH_PERCENT);
          add_byte(rand_hex());
          add_byte(8'($urandom_range(0, 255)));
        end
      end
      // Now and then leave an escape open at the end.
      k = $urandom_range(0, 9);
      if (k == 0) begin
        add_byte(CH_PERCENT);
      end else if (k == 1) begin
        add_byte(CH_PERCENT);
        add_byte(rand_hex());
      end
      send_msg();

      // Hold off the receiver while requests keep coming.
      if (!held_once && reqs_sent >= 70) begin
        held_once = 1'b1;
        long_hold = 1'b1;
      end
      // Pause the sender until the output has caught up.
      if (!paused_once && reqs_sent >= 140) begin
        paused_once = 1'b1;
        up_valid <= 1'b0;
        wait (outstanding == 0);
        @(negedge clk);
      end
      // Run the tail at full rate on both sides.
      if (reqs_sent >= 185) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
    end

    up_valid <= 1'b0;
    wait (outstanding == 0);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/urlpd_pkg.sv
src/urlpd_front.sv
src/urlpd_queue.sv
src/urlpd_back.sv
src/url_percent_decoder.sv
dv/urlpd_checker.sv
dv/tb_url_percent_decoder.sv
